// File: design/dfr_pkg.sv
// shared types, constants and helpers for the byte stream deframer
// no dependencies
`default_nettype none

package dfr_pkg;

  localparam int unsigned BufDepthDefault = 64;
  localparam int unsigned MaxResults      = 64;
  localparam int unsigned NresW           = $clog2(MaxResults + 1);
  localparam int unsigned TotW            = 17;

  localparam logic [7:0] SyncHi   = 8'hAA;
  localparam logic [7:0] SyncLo   = 8'h55;
  localparam logic [7:0] TailHi   = 8'hDD;
  localparam logic [7:0] TailLo   = 8'hEE;
  localparam logic [7:0] NewLine  = 8'h0A;
  localparam int unsigned FrameOverhead = 8;
  localparam int unsigned MinParse      = 4;

  typedef enum logic [1:0] {
    KIND_TEXT     = 2'd0,
    KIND_FRAME    = 2'd1,
    KIND_BAD_SUM  = 2'd2,
    KIND_OVERFLOW = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    IDX_HOLD, IDX_ZERO, IDX_ONE, IDX_TWO, IDX_THREE, IDX_FIVE, IDX_INC,
    IDX_TOT_M1, IDX_TOT_M2, IDX_TOT_M3, IDX_START
  } idx_op_e;

  typedef enum logic [1:0] {
    DROP_NONE, DROP_TWO, DROP_FRAME, DROP_LINE
  } drop_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_OVF, ST_CHK, ST_B0, ST_B1, ST_LEN_HI, ST_LEN_LO, ST_LEN_CK,
    ST_TAIL0, ST_TAIL1, ST_SUM, ST_SUM_CK, ST_FRAME_OUT, ST_SCAN, ST_LINE_DROP,
    ST_LINE_OUT
  } state_e;

  typedef struct packed {
    logic    store;
    logic    nres_clr;
    idx_op_e idx_op;
    logic    ld_b0;
    logic    ld_len_hi;
    logic    ld_len_lo;
    logic    sum_clr;
    logic    sum_acc;
    logic    txt_clr;
    logic    txt_acc;
    logic    ld_nl;
    drop_e   drop;
    logic    emit;
    kind_e   kind;
    logic    data_rd;
    logic    func_en;
    logic    empty;
    logic    last;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic ge4;
    logic nres_full;
    logic nres_lim;
    logic short_frame;
    logic b0_aa;
    logic rd_55;
    logic rd_dd;
    logic rd_ee;
    logic rd_nl;
    logic sum_ok;
    logic len_zero;
    logic frame_end;
    logic text_end;
    logic scan_end;
    logic txt_nz;
    logic out_free;
  } sts_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0B) ||
           (c == 8'h0C) || (c == 8'h0D);
  endfunction

endpackage

`default_nettype wire

// File: design/dfr_ctrl.sv
// parse sequencer of the deframer: walks the buffer one read at a time
// depends on dfr_pkg
`default_nettype none

module dfr_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire dfr_pkg::sts_t sts_i,
  output dfr_pkg::cmd_t      cmd_o
);
  import dfr_pkg::*;

  state_e state_q, state_d;
  logic   ph_q, ph_d;
  cmd_t   c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ph_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ph_q    <= ph_d;
    end
  end

  always_comb begin
    c         = '0;
    c.idx_op  = IDX_HOLD;
    c.drop    = DROP_NONE;
    c.kind    = KIND_TEXT;
    state_d   = state_q;
    in_stall_o = (state_q != ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          c.store    = 1'b1;
          c.nres_clr = 1'b1;
          state_d    = sts_i.full ? ST_OVF : ST_CHK;
        end
      end
      ST_OVF: begin
        if (sts_i.out_free) begin
          c.emit  = 1'b1;
          c.kind  = KIND_OVERFLOW;
          c.last  = 1'b1;
          state_d = ST_CHK;
        end
      end
      ST_CHK: begin
        if (sts_i.ge4 && !sts_i.nres_full) begin
          c.idx_op = IDX_ZERO;
          state_d  = ST_B0;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_B0: begin
        if (ph_q) begin
          c.ld_b0  = 1'b1;
          c.idx_op = IDX_ONE;
          state_d  = ST_B1;
        end
      end
      ST_B1: begin
        if (ph_q) begin
          if (sts_i.b0_aa && sts_i.rd_55) begin
            c.idx_op = IDX_TWO;
            state_d  = ST_LEN_HI;
          end else begin
            c.txt_clr = 1'b1;
            c.idx_op  = IDX_ZERO;
            state_d   = ST_SCAN;
          end
        end
      end
      ST_LEN_HI: begin
        if (ph_q) begin
          c.ld_len_hi = 1'b1;
          c.idx_op    = IDX_THREE;
          state_d     = ST_LEN_LO;
        end
      end
      ST_LEN_LO: begin
        if (ph_q) begin
          c.ld_len_lo = 1'b1;
          state_d     = ST_LEN_CK;
        end
      end
      ST_LEN_CK: begin
        if (sts_i.short_frame) begin
          state_d = ST_IDLE;
        end else begin
          c.idx_op = IDX_TOT_M2;
          state_d  = ST_TAIL0;
        end
      end
      ST_TAIL0: begin
        if (ph_q) begin
          if (!sts_i.rd_dd) begin
            c.drop  = DROP_TWO;
            state_d = ST_CHK;
          end else begin
            c.idx_op = IDX_TOT_M1;
            state_d  = ST_TAIL1;
          end
        end
      end
      ST_TAIL1: begin
        if (ph_q) begin
          if (!sts_i.rd_ee) begin
            c.drop  = DROP_TWO;
            state_d = ST_CHK;
          end else begin
            c.sum_clr = 1'b1;
            c.idx_op  = IDX_TWO;
            state_d   = ST_SUM;
          end
        end
      end
      ST_SUM: begin
        if (ph_q) begin
          c.sum_acc = 1'b1;
          if (sts_i.frame_end) begin
            c.idx_op = IDX_TOT_M3;
            state_d  = ST_SUM_CK;
          end else begin
            c.idx_op = IDX_INC;
          end
        end
      end
      ST_SUM_CK: begin
        if (ph_q) begin
          if (!sts_i.sum_ok || sts_i.len_zero) begin
            if (sts_i.out_free) begin
              c.emit    = 1'b1;
              c.kind    = sts_i.sum_ok ? KIND_FRAME : KIND_BAD_SUM;
              c.func_en = 1'b1;
              c.empty   = sts_i.sum_ok;
              c.last    = 1'b1;
              c.drop    = DROP_FRAME;
              state_d   = ST_CHK;
            end
          end else begin
            c.idx_op = IDX_FIVE;
            state_d  = ST_FRAME_OUT;
          end
        end
      end
      ST_FRAME_OUT: begin
        if (ph_q && sts_i.out_free) begin
          c.emit    = 1'b1;
          c.kind    = KIND_FRAME;
          c.data_rd = 1'b1;
          c.func_en = 1'b1;
          c.last    = sts_i.frame_end || sts_i.nres_lim;
          if (c.last) begin
            c.drop  = DROP_FRAME;
            state_d = ST_CHK;
          end else begin
            c.idx_op = IDX_INC;
          end
        end
      end
      ST_SCAN: begin
        if (ph_q) begin
          if (sts_i.rd_nl) begin
            c.ld_nl = 1'b1;
            if (sts_i.txt_nz) begin
              c.idx_op = IDX_START;
              state_d  = ST_LINE_OUT;
            end else begin
              state_d = ST_LINE_DROP;
            end
          end else begin
            c.txt_acc = 1'b1;
            if (sts_i.scan_end) begin
              state_d = ST_IDLE;
            end else begin
              c.idx_op = IDX_INC;
            end
          end
        end
      end
      ST_LINE_DROP: begin
        c.drop  = DROP_LINE;
        state_d = ST_CHK;
      end
      ST_LINE_OUT: begin
        if (ph_q && sts_i.out_free) begin
          c.emit    = 1'b1;
          c.kind    = KIND_TEXT;
          c.data_rd = 1'b1;
          c.last    = sts_i.text_end || sts_i.nres_lim;
          if (c.last) begin
            c.drop  = DROP_LINE;
            state_d = ST_CHK;
          end else begin
            c.idx_op = IDX_INC;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    // read data is taken only once the registered read has caught up with a stable read offset
    ph_d  = (state_d == state_q) && (c.idx_op == IDX_HOLD);
    cmd_o = c;
  end

endmodule

`default_nettype wire

// File: design/dfr_dp.sv
// deframer datapath: circular byte buffer, read offset, parse registers, result register
// depends on dfr_pkg
`default_nettype none

module dfr_dp #(
  parameter int unsigned BufDepth = dfr_pkg::BufDepthDefault
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic [7:0]    rx_byte_i,
  input  wire logic          out_stall_i,
  input  wire dfr_pkg::cmd_t cmd_i,
  output dfr_pkg::sts_t      sts_o,
  output logic               out_valid_o,
  output logic [1:0]         record_kind_o,
  output logic [7:0]         data_byte_o,
  output logic [7:0]         func_code_o,
  output logic               empty_payload_o,
  output logic               last_o
);
  import dfr_pkg::*;

  localparam int unsigned AW = $clog2(BufDepth);
  localparam int unsigned CW = $clog2(BufDepth + 1);
  localparam logic [CW:0] DepthW = (CW + 1)'(BufDepth);

  logic [7:0]      mem_q [BufDepth];
  logic [7:0]      rd_q;
  logic [AW-1:0]   head_q, head_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [CW-1:0]   idx_q, idx_d;
  logic [CW-1:0]   wr_off, drop_n;
  logic [AW-1:0]   wr_addr, rd_addr;
  logic [7:0]      b0_q, sum_q, func_q;
  logic [15:0]     len_q;
  logic [TotW-1:0] total, frame_last;
  logic [CW-1:0]   s_q, e_q, nl_q;
  logic            nz_q;
  logic [NresW-1:0] nres_q;
  logic            out_valid_q;
  logic [1:0]      kind_q;
  logic [7:0]      data_q, fcode_q;
  logic            empty_q, last_q;
  logic            out_free;

  function automatic logic [AW-1:0] wrap(input logic [AW-1:0] base, input logic [CW-1:0] off);
    logic [CW:0] s;
    s = (CW + 1)'(base) + (CW + 1)'(off);
    if (s >= DepthW) begin
      s = s - DepthW;
    end
    return s[AW-1:0];
  endfunction

  assign total      = TotW'(FrameOverhead) + TotW'(len_q);
  assign frame_last = TotW'(4) + TotW'(len_q);
  assign wr_off     = (cnt_q >= CW'(BufDepth)) ? '0 : cnt_q;
  assign wr_addr    = wrap(head_q, wr_off);
  assign rd_addr    = wrap(head_q, idx_q);
  assign out_free   = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      mem_q[wr_addr] <= rx_byte_i;
    end
    rd_q <= mem_q[rd_addr];
  end

  always_comb begin
    case (cmd_i.drop)
      DROP_TWO:   drop_n = CW'(2);
      DROP_FRAME: drop_n = total[CW-1:0];
      DROP_LINE:  drop_n = nl_q + CW'(1);
      default:    drop_n = '0;
    endcase
    head_d = head_q;
    cnt_d  = cnt_q;
    if (cmd_i.store) begin
      cnt_d = wr_off + CW'(1);
    end else if (cmd_i.drop != DROP_NONE) begin
      head_d = wrap(head_q, drop_n);
      cnt_d  = cnt_q - drop_n;
    end
  end

  always_comb begin
    case (cmd_i.idx_op)
      IDX_ZERO:   idx_d = '0;
      IDX_ONE:    idx_d = CW'(1);
      IDX_TWO:    idx_d = CW'(2);
      IDX_THREE:  idx_d = CW'(3);
      IDX_FIVE:   idx_d = CW'(5);
      IDX_INC:    idx_d = idx_q + CW'(1);
      IDX_TOT_M1: idx_d = CW'(total - TotW'(1));
      IDX_TOT_M2: idx_d = CW'(total - TotW'(2));
      IDX_TOT_M3: idx_d = CW'(total - TotW'(3));
      IDX_START:  idx_d = s_q;
      default:    idx_d = idx_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      cnt_q       <= '0;
      idx_q       <= '0;
      nres_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      head_q <= head_d;
      cnt_q  <= cnt_d;
      idx_q  <= idx_d;
      if (cmd_i.nres_clr) begin
        nres_q <= '0;
      end else if (cmd_i.emit) begin
        nres_q <= nres_q + NresW'(1);
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // parse and result payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_b0)     b0_q        <= rd_q;
    if (cmd_i.ld_len_hi) len_q[15:8] <= rd_q;
    if (cmd_i.ld_len_lo) len_q[7:0]  <= rd_q;
    if (cmd_i.sum_clr) begin
      sum_q <= '0;
    end else if (cmd_i.sum_acc) begin
      sum_q <= sum_q ^ rd_q;
      if (idx_q == CW'(4)) begin
        func_q <= rd_q;
      end
    end
    if (cmd_i.txt_clr) begin
      nz_q <= 1'b0;
    end else if (cmd_i.txt_acc && !is_space(rd_q)) begin
      if (!nz_q) begin
        s_q <= idx_q;
      end
      nz_q <= 1'b1;
      e_q  <= idx_q + CW'(1);
    end
    if (cmd_i.ld_nl) nl_q <= idx_q;
    if (cmd_i.emit) begin
      kind_q  <= cmd_i.kind;
      data_q  <= cmd_i.data_rd ? rd_q : 8'h00;
      fcode_q <= cmd_i.func_en ? func_q : 8'h00;
      empty_q <= cmd_i.empty;
      last_q  <= cmd_i.last;
    end
  end

  always_comb begin
    sts_o.full        = (cnt_q >= CW'(BufDepth));
    sts_o.ge4         = (cnt_q >= CW'(MinParse));
    sts_o.nres_full   = (nres_q >= NresW'(MaxResults));
    sts_o.nres_lim    = (nres_q + NresW'(1) == NresW'(MaxResults));
    sts_o.short_frame = (TotW'(cnt_q) < total);
    sts_o.b0_aa       = (b0_q == SyncHi);
    sts_o.rd_55       = (rd_q == SyncLo);
    sts_o.rd_dd       = (rd_q == TailHi);
    sts_o.rd_ee       = (rd_q == TailLo);
    sts_o.rd_nl       = (rd_q == NewLine);
    sts_o.sum_ok      = (sum_q == rd_q);
    sts_o.len_zero    = (len_q == 16'h0000);
    sts_o.frame_end   = (TotW'(idx_q) == frame_last);
    sts_o.text_end    = (idx_q + CW'(1) == e_q);
    sts_o.scan_end    = (idx_q + CW'(1) == cnt_q);
    sts_o.txt_nz      = nz_q;
    sts_o.out_free    = out_free;
  end

  assign out_valid_o     = out_valid_q;
  assign record_kind_o   = kind_q;
  assign data_byte_o     = data_q;
  assign func_code_o     = fcode_q;
  assign empty_payload_o = empty_q;
  assign last_o          = last_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(BufDepth)) else $error("fill count beyond depth");
  a_head_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q < AW'(BufDepth - 1) || head_q == AW'(BufDepth - 1))
    else $error("head pointer out of range");
  a_nres_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nres_q <= NresW'(MaxResults)) else $error("result count beyond limit");
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> out_free) else $error("result written over a waiting result");
  a_drop_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.drop != DROP_NONE |-> drop_n <= cnt_q) else $error("drop beyond fill");

endmodule

`default_nettype wire

// File: design/mixed_frame_and_line_deframer_unit.sv
// top level of the byte stream deframer: sequencer plus datapath
// depends on dfr_pkg, dfr_ctrl, dfr_dp
`default_nettype none

// Byte stream deframer. Each accepted byte goes into a circular buffer of
// BufDepth bytes; once four or more bytes are held, the buffer front is parsed
// as a binary frame (AA 55, 16-bit big-endian length, function byte, data,
// XOR check byte, DD EE) or as a text line ending in a newline, trimmed of
// ASCII whitespace. A good frame yields one result per data byte (one empty
// result when the length is zero), a bad check byte one error result, a bad
// tail drops the two sync bytes and reparses, and a byte arriving into a full
// buffer clears it and yields one overflow result. The buffer has a single
// registered read port, so every buffer byte the parser looks at waits for
// that registered read. While text waits for its newline, the line is
// rescanned from the buffer front on every byte, and a frame is read twice:
// once for the XOR check, once to release its results. At most 64 results
// come from one input byte. The input is held off (in_stall_o high) while
// parsing; a released result sits in an output register so the next byte
// can be taken while it waits. The buffer needs no clearing after reset.

module mixed_frame_and_line_deframer_unit #(
  parameter int unsigned BufDepth = dfr_pkg::BufDepthDefault
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // input byte channel
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] rx_byte_i,
  // result channel
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [1:0]      record_kind_o,
  output logic [7:0]      data_byte_o,
  output logic [7:0]      func_code_o,
  output logic            empty_payload_o,
  output logic            last_o
);
  import dfr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer decides what to read, keep, drop and release
  dfr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // buffer, pointers, check sum and the result register
  dfr_dp #(
    .BufDepth (BufDepth)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .rx_byte_i       (rx_byte_i),
    .out_stall_i     (out_stall_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_valid_o     (out_valid_o),
    .record_kind_o   (record_kind_o),
    .data_byte_o     (data_byte_o),
    .func_code_o     (func_code_o),
    .empty_payload_o (empty_payload_o),
    .last_o          (last_o)
  );

endmodule

`default_nettype wire
